// ----- sv/assert_macros.svh -----
// assertion helper macros used by crc_packet_frame_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/cpfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_pkg
// types, constants and the crc byte update for the packet frame checker
// ----------------------------------------------------------------------------
package cpfc_pkg;

    // frame constants
    localparam logic [7:0]  FRAME_MARKER = 8'h7E;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [5:0]  LEN_MIN      = 6'd2;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status STATUS_VALID      = 2'd0;
    localparam t_status STATUS_BAD_MARKER = 2'd1;
    localparam t_status STATUS_BAD_LENGTH = 2'd2;
    localparam t_status STATUS_CRC_ERROR  = 2'd3;

    // one received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    // one packet result
    typedef struct packed {
        t_status     status;
        logic [1:0]  packet_kind;
        logic [7:0]  sequence_number;
        logic [7:0]  command_code;
        logic [5:0]  frame_length;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } t_result;

    // crc-16/ccitt (poly 0x1021) update by one byte, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  x;
        logic [15:0] xw;
        x  = crc[15:8] ^ b;
        x  = x ^ (x >> 4);
        xw = {8'h00, x};
        return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
    endfunction

endpackage

// ----- sv/cpfc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface cpfc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/crc_packet_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_packet_frame_checker
// received packet checker: marker, length and crc-16/ccitt over a byte stream
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the input is not stalled and gives
// one result per packet (valid, bad marker, bad length or crc mismatch) at
// the byte that decides it. Each byte passes an input register, then the
// bytewise crc update and frame tracking run combinationally into the result
// register, so a new byte can be taken every cycle as long as results drain.
// The input register absorbs one more byte while a result waits on the
// output; after that the input stalls until the result is transferred.
`include "assert_macros.svh"

module crc_packet_frame_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    cpfc_stream_if.sink   i_in,
    cpfc_stream_if.source o_out
);
    import cpfc_pkg::*;

    logic     r_s1_valid;
    t_in_item r_s1_item;
    logic     r_out_valid;
    t_result  r_out;

    logic     s1_advance;
    logic     core_emit;
    t_result  core_result;

    // input register moves on when the result slot is free or draining
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
    end

    cpfc_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_advance),
        .i_item   (r_s1_item),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= core_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && core_emit) begin
            r_out <= core_result;
        end
    end

    // checks
    `ASSERT_CLK_RST(a_stall_only_when_full, i_clk, i_rst_n, !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready), "input stalled with room to spare")
    `ASSERT_CLK_RST(a_valid_crc_match, i_clk, i_rst_n, (r_out_valid && (r_out.status == STATUS_VALID)) |-> (r_out.computed_crc == r_out.received_crc), "valid status with crc mismatch")
    `ASSERT_CLK_RST(a_bad_marker_clear, i_clk, i_rst_n, (r_out_valid && (r_out.status == STATUS_BAD_MARKER)) |-> ((r_out.frame_length == 6'd0) && (r_out.computed_crc == 16'd0)), "bad marker result carries fields")
    `ASSERT_CLK(a_reset_clears_out, i_clk, !i_rst_n |=> (!r_out_valid && !r_s1_valid), "pipeline valid after reset")

endmodule

// ----- sv/cpfc_frame_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_frame_core
// per-byte frame tracking, field capture and crc accumulation
// ----------------------------------------------------------------------------
module cpfc_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  cpfc_pkg::t_in_item i_item,
    output logic              o_emit,
    output cpfc_pkg::t_result o_result
);
    import cpfc_pkg::*;

    logic        r_frame_active, n_frame_active;
    logic [15:0] r_crc,          n_crc;
    logic [5:0]  r_pos,          n_pos;
    logic [5:0]  r_len,          n_len;
    logic [1:0]  r_kind,         n_kind;
    logic [7:0]  r_seq,          n_seq;
    logic [7:0]  r_cmd,          n_cmd;
    logic [7:0]  r_crc_lo,       n_crc_lo;

    logic [7:0]  b;
    logic [15:0] rx_crc;

    assign b      = i_item.data_byte;
    assign rx_crc = {b, r_crc_lo};

    // next frame state and result for the byte in flight
    always_comb begin
        n_frame_active = r_frame_active;
        n_crc          = r_crc;
        n_pos          = r_pos;
        n_len          = r_len;
        n_kind         = r_kind;
        n_seq          = r_seq;
        n_cmd          = r_cmd;
        n_crc_lo       = r_crc_lo;
        o_emit         = 1'b0;
        o_result       = '0;

        if (i_item.frame_start) begin
            // new packet: drop whatever was in progress
            n_frame_active = 1'b0;
            n_crc          = CRC_SEED;
            n_pos          = '0;
            n_len          = '0;
            n_kind         = '0;
            n_seq          = '0;
            n_cmd          = '0;
            n_crc_lo       = '0;
            if (b != FRAME_MARKER) begin
                o_emit          = 1'b1;
                o_result.status = STATUS_BAD_MARKER;
            end else begin
                n_crc          = crc_update(CRC_SEED, b);
                n_pos          = 6'd1;
                n_frame_active = 1'b1;
            end
        end else if (r_frame_active) begin
            if (r_pos == 6'd1) begin
                n_len  = b[5:0];
                n_kind = b[7:6];
            end
            if ((r_pos == 6'd1) && (b[5:0] < LEN_MIN)) begin
                // length too short to hold a crc
                o_emit                = 1'b1;
                o_result.status       = STATUS_BAD_LENGTH;
                o_result.packet_kind  = b[7:6];
                o_result.frame_length = b[5:0];
                n_frame_active        = 1'b0;
            end else begin
                if (r_pos == 6'd2) n_seq = b;
                if (r_pos == 6'd3) n_cmd = b;
                if (({1'b0, r_pos} + 7'd2) <= {1'b0, n_len}) n_crc = crc_update(r_crc, b);
                if (({1'b0, r_pos} + 7'd1) == {1'b0, n_len}) n_crc_lo = b;
                if (r_pos == n_len) begin
                    // last byte: compare carried crc with accumulated one
                    o_emit                   = 1'b1;
                    o_result.status          = (rx_crc == r_crc) ? STATUS_VALID
                                                                 : STATUS_CRC_ERROR;
                    o_result.packet_kind     = n_kind;
                    o_result.sequence_number = n_seq;
                    o_result.command_code    = n_cmd;
                    o_result.frame_length    = n_len;
                    o_result.computed_crc    = r_crc;
                    o_result.received_crc    = rx_crc;
                    n_frame_active           = 1'b0;
                end else begin
                    n_pos = r_pos + 6'd1;
                end
            end
        end
    end

    // frame state registers, updated once per byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_crc          <= CRC_SEED;
            r_pos          <= '0;
            r_len          <= '0;
            r_kind         <= '0;
            r_seq          <= '0;
            r_cmd          <= '0;
            r_crc_lo       <= '0;
        end else if (i_step) begin
            r_frame_active <= n_frame_active;
            r_crc          <= n_crc;
            r_pos          <= n_pos;
            r_len          <= n_len;
            r_kind         <= n_kind;
            r_seq          <= n_seq;
            r_cmd          <= n_cmd;
            r_crc_lo       <= n_crc_lo;
        end
    end

endmodule
